@@ src/rle_pixel_run_decoder_core_macros.svh @@
// assertion macros used by the decoder checker
`ifndef RLE_PIXEL_RUN_DECODER_CORE_MACROS_SVH
`define RLE_PIXEL_RUN_DECODER_CORE_MACROS_SVH

// clocked check, masked while reset is active
`define RLE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// clocked check that also holds during reset
`define RLE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

@@ src/rle_pkg.sv @@
// types and constants of the run-length pixel decoder
package rle_pkg;

  localparam int unsigned PalEntries  = 256;
  localparam int unsigned PalIdxW     = $clog2(PalEntries);
  localparam int unsigned PixelW      = 32;
  localparam int unsigned CountW      = 24;
  localparam int unsigned RunW        = 8;
  localparam int unsigned CfgDataW    = 24;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [CfgIdxW-1:0] CfgPaletteMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgOutLimit    = 1'b1;

  localparam logic [CountW-1:0] OutLimitReset = '1;
  localparam logic [RunW-1:0]   RepeatBias    = 8'd3;

  typedef enum logic [2:0] {
    PhHeader  = 3'b001,
    PhRepeat  = 3'b010,
    PhLiteral = 3'b100
  } phase_e;

  typedef struct packed {
    logic              mode;
    logic [7:0]        data_byte;
    logic [7:0]        palette_index;
    logic [PixelW-1:0] palette_word;
    logic              end_of_chunk;
  } in_item_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic [RunW-1:0]   run_length;
    logic              final_res;
  } out_item_t;

endpackage

@@ src/rle_pixel_run_decoder_core.sv @@
// top level of the run-length pixel decoder
//
// Input channel (in_valid_i/in_ready_o/in_item_i) takes one item per transfer:
// mode 0 carries one compressed chunk byte, mode 1 loads one palette entry.
// Output channel (out_valid_o/out_ready_i/out_item_o) gives a pixel with its
// run length and a final flag; each data byte gives zero or one result.
// Throughput is one item per cycle, back to back, while results are taken.
// The transfer loads the decode stage and starts the palette ram read; the
// output register then loads from the decode stage once it may move.
// The palette lives in a 256 x 32 ram with a registered read port; loads
// write it in their transfer cycle, so a colour byte right after a load of
// the same entry sees the new word.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and the user must make them only while the block is idle (not enforced).
// Reset clears the decode state, the pipeline and the registers; the
// palette is undefined until loaded. When the receiver stalls, the result
// holds in the output register and one more in the decode stage, after
// which in_ready_o drops until the output moves.
module rle_pixel_run_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rle_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rle_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [rle_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rle_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic                         pal_mode_q;
  logic [rle_pkg::CountW-1:0]   limit_q;

  rle_pkg::phase_e              phase_q, phase_d;
  logic [rle_pkg::RunW-1:0]     plr_q, plr_d;
  logic [1:0]                   bic_q, bic_d;
  logic [rle_pkg::PixelW-1:0]   acc_q, acc_d;
  logic [rle_pkg::CountW-1:0]   written_q, written_d;
  logic                         stopped_q, stopped_d;

  logic                         s1_valid_q;
  logic                         s1_pal_q;
  rle_pkg::out_item_t           s1_item_q;
  logic                         out_valid_q;
  rle_pkg::out_item_t           out_item_q;

  logic                         in_fire, data_fire, s1_go;
  logic                         have, fin, use_pal, done;
  logic [rle_pkg::PixelW-1:0]   pix, acc_new;
  logic [rle_pkg::RunW-1:0]     run, plr_dec;
  logic [rle_pkg::CountW-1:0]   left;
  logic [rle_pkg::PixelW-1:0]   pal_rdata;
  logic [7:0]                   db;

  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;
  assign data_fire  = in_fire && !in_item_i.mode;
  assign db         = in_item_i.data_byte;

  rle_ram #(
    .Width (rle_pkg::PixelW),
    .Depth (rle_pkg::PalEntries)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && in_item_i.mode),
    .waddr_i (in_item_i.palette_index[rle_pkg::PalIdxW-1:0]),
    .wdata_i (in_item_i.palette_word),
    .re_i    (data_fire),
    .raddr_i (db[rle_pkg::PalIdxW-1:0]),
    .rdata_o (pal_rdata)
  );

  always_comb begin
    phase_d   = phase_q;
    plr_d     = plr_q;
    bic_d     = bic_q;
    acc_d     = acc_q;
    written_d = written_q;
    stopped_d = stopped_q;
    have      = 1'b0;
    fin       = 1'b0;
    use_pal   = 1'b0;
    done      = 1'b0;
    pix       = '0;
    run       = '0;
    acc_new   = acc_q;
    plr_dec   = '0;
    left      = (limit_q > written_q) ? (limit_q - written_q) : '0;
    if (data_fire) begin
      if (!stopped_q) begin
        if (left == '0) begin
          stopped_d = 1'b1;
          have      = 1'b1;
          fin       = 1'b1;
        end else if (phase_q == rle_pkg::PhHeader) begin
          if (db[7]) begin
            plr_d   = {1'b0, db[6:0]} + rle_pkg::RepeatBias;
            phase_d = rle_pkg::PhRepeat;
          end else begin
            plr_d   = db + 8'd1;
            phase_d = rle_pkg::PhLiteral;
          end
          bic_d = '0;
        end else begin
          if (pal_mode_q) begin
            use_pal = 1'b1;
            bic_d   = '0;
            done    = 1'b1;
          end else begin
            if (bic_q == 2'd0) begin
              acc_new = {24'd0, db};
            end else begin
              acc_new = acc_q | ({24'd0, db} << {bic_q, 3'b000});
            end
            acc_d = acc_new;
            bic_d = bic_q + 2'd1;
            if (bic_q == 2'd3) begin
              pix  = acc_new;
              done = 1'b1;
            end
          end
          if (done) begin
            if (phase_q == rle_pkg::PhRepeat) begin
              run     = (rle_pkg::CountW'(plr_q) > left) ? left[rle_pkg::RunW-1:0] : plr_q;
              plr_d   = '0;
              phase_d = rle_pkg::PhHeader;
            end else begin
              run     = 8'd1;
              plr_dec = (plr_q == '0) ? '0 : plr_q - 8'd1;
              plr_d   = plr_dec;
              if (plr_dec == '0) begin
                phase_d = rle_pkg::PhHeader;
              end
            end
            written_d = written_q + rle_pkg::CountW'(run);
            have      = 1'b1;
            if (written_d >= limit_q) begin
              fin       = 1'b1;
              stopped_d = 1'b1;
            end
          end
        end
      end
      if (in_item_i.end_of_chunk) begin
        if (!stopped_q) begin
          have = 1'b1;
          fin  = 1'b1;
        end
        phase_d   = rle_pkg::PhHeader;
        plr_d     = '0;
        bic_d     = '0;
        acc_d     = '0;
        written_d = '0;
        stopped_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_mode_q <= 1'b0;
      limit_q    <= rle_pkg::OutLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rle_pkg::CfgPaletteMode: pal_mode_q <= cfg_data_i[0];
        rle_pkg::CfgOutLimit:    limit_q    <= cfg_data_i[rle_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rle_pkg::PhHeader;
      plr_q     <= '0;
      bic_q     <= '0;
      acc_q     <= '0;
      written_q <= '0;
      stopped_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      plr_q     <= plr_d;
      bic_q     <= bic_d;
      acc_q     <= acc_d;
      written_q <= written_d;
      stopped_q <= stopped_d;
    end
  end

  // decode stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= data_fire && have;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_fire && in_ready_o) begin
      s1_pal_q             <= use_pal;
      s1_item_q.pixel      <= pix;
      s1_item_q.run_length <= run;
      s1_item_q.final_res  <= fin;
    end
    if (s1_go) begin
      out_item_q.pixel      <= s1_pal_q ? pal_rdata : s1_item_q.pixel;
      out_item_q.run_length <= s1_item_q.run_length;
      out_item_q.final_res  <= s1_item_q.final_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ src/rle_ram.sv @@
// generic single-port-write ram with registered read
module rle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rle_chk.sv @@
// port checker for the run-length pixel decoder, bound to the top level
`include "rle_pixel_run_decoder_core_macros.svh"

module rle_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input rle_pkg::out_item_t           out_item_o
);

  // stalled result stays put
  `RLE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))

  // a run never exceeds the longest repeat header
  `RLE_ASSERT(a_run_max, clk_i, rst_ni, out_valid_o |-> out_item_o.run_length <= 8'd130)

  // zero and two pixel runs only come from a final marker or a cut repeat run
  `RLE_ASSERT(a_short_final, clk_i, rst_ni, out_valid_o && (out_item_o.run_length == 8'd0 || out_item_o.run_length == 8'd2) |-> out_item_o.final_res)

  // no result while in reset
  `RLE_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind rle_pixel_run_decoder_core rle_chk u_rle_chk (.*);

@@ sim/rle_pixel_run_decoder_core_tb.sv @@
// self-checking testbench for rle_pixel_run_decoder_core with a built-in decode predictor
`timescale 1ns / 100ps

module rle_pixel_run_decoder_core_tb;

  localparam int RandItems      = 650;
  localparam int WatchdogCycles = 2000;
  localparam int DirRows        = 32;

  typedef enum logic [1:0] {RowData, RowLoad, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [7:0]         sel;
    logic [31:0]        word;
    logic               eoc;
    logic               typed;
    rle_pkg::out_item_t want;
  } dir_row_t;

  localparam dir_row_t DirTable [DirRows] = '{
    '{RowCfg,  8'(rle_pkg::CfgOutLimit),    32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'h00,              32'h0,        1'b0, 1'b1, '{32'h0, 8'd0, 1'b1}},
    '{RowData, 8'hff,              32'h0,        1'b1, 1'b0, '0},
    '{RowCfg,  8'(rle_pkg::CfgOutLimit),    32'hffffff,   1'b0, 1'b0, '0},
    '{RowData, 8'h80,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'hff,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'h00,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'haa,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'h55,              32'h0,        1'b0, 1'b1, '{32'h55aa00ff, 8'd3, 1'b0}},
    '{RowData, 8'hff,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'h00,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'h00,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'h00,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'h00,              32'h0,        1'b0, 1'b1, '{32'h0, 8'd130, 1'b0}},
    '{RowData, 8'h7f,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'h01,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'h02,              32'h0,        1'b1, 1'b1, '{32'h0, 8'd0, 1'b1}},
    '{RowCfg,  8'(rle_pkg::CfgPaletteMode), 32'h1,        1'b0, 1'b0, '0},
    '{RowCfg,  8'(rle_pkg::CfgOutLimit),    32'h5,        1'b0, 1'b0, '0},
    '{RowLoad, 8'hff,              32'hffffffff, 1'b1, 1'b0, '0},
    '{RowLoad, 8'h00,              32'hdeadbeef, 1'b0, 1'b0, '0},
    '{RowData, 8'h85,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'hff,              32'h0,        1'b0, 1'b1, '{32'hffffffff, 8'd5, 1'b1}},
    '{RowData, 8'h00,              32'h0,        1'b1, 1'b0, '0},
    '{RowCfg,  8'(rle_pkg::CfgPaletteMode), 32'h0,        1'b0, 1'b0, '0},
    '{RowCfg,  8'(rle_pkg::CfgOutLimit),    32'hffffff,   1'b0, 1'b0, '0},
    '{RowData, 8'h01,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'h11,              32'h0,        1'b0, 1'b0, '0},
    '{RowData, 8'h22,              32'h0,        1'b0, 1'b0, '0},
    '{RowCfg,  8'(rle_pkg::CfgPaletteMode), 32'h1,        1'b0, 1'b0, '0},
    '{RowData, 8'h00,              32'h0,        1'b0, 1'b1, '{32'hdeadbeef, 8'd1, 1'b0}},
    '{RowData, 8'h00,              32'h0,        1'b1, 1'b1, '{32'hdeadbeef, 8'd1, 1'b1}}
  };

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  rle_pkg::in_item_t            in_item_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  rle_pkg::out_item_t           out_item_o;
  logic                         cfg_we_i;
  logic [rle_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [rle_pkg::CfgDataW-1:0] cfg_data_i;

  // predictor state
  rle_pkg::phase_e              phase = rle_pkg::PhHeader;
  logic [7:0]                   run_left = '0;
  logic [1:0]                   col_byte = '0;
  logic [31:0]                  col_acc = '0;
  logic [rle_pkg::CountW-1:0]   px_count = '0;
  bit                           halted = 1'b0;
  logic [31:0]                  pal_mem [rle_pkg::PalEntries];
  bit                           pal_written [rle_pkg::PalEntries];
  bit                           cfg_pal_mode = 1'b0;
  logic [rle_pkg::CountW-1:0]   cfg_limit = rle_pkg::OutLimitReset;

  rle_pkg::out_item_t           pending_pixels [$];
  rle_pkg::out_item_t           want_pix;
  int                           fails = 0;
  int                           results_seen = 0;
  int                           transfers = 0;
  int                           live_items = 0;
  int                           cfg_writes = 0;
  int                           chunks = 0;
  int                           idle_cycles = 0;
  int unsigned                  next_gap = 0;
  bit                           src_hold = 1'b0;
  bit                           src_calm = 1'b0;
  bit                           sink_calm = 1'b0;

  rle_pixel_run_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void rearm_decoder();
    phase    = rle_pkg::PhHeader;
    run_left = '0;
    col_byte = '0;
    col_acc  = '0;
    px_count = '0;
    halted   = 1'b0;
  endfunction

  function automatic logic [rle_pkg::CountW-1:0] room_left();
    return (cfg_limit > px_count) ? cfg_limit - px_count : '0;
  endfunction

  function automatic void decode_item(input rle_pkg::in_item_t it, output bit got,
                                      output rle_pkg::out_item_t res);
    logic [rle_pkg::CountW-1:0] room;
    logic [7:0]                 run;
    logic [31:0]                pix;
    bit                         was_halted, fin, done;
    got = 1'b0;
    fin = 1'b0;
    done = 1'b0;
    run = '0;
    pix = '0;
    res = '0;
    was_halted = halted;
    if (it.mode) begin
      pal_mem[it.palette_index] = it.palette_word;
      pal_written[it.palette_index] = 1'b1;
      live_items++;
      return;
    end
    if (!halted || it.end_of_chunk) live_items++;
    room = room_left();
    if (!halted) begin
      if (room == '0) begin
        halted = 1'b1;
        got = 1'b1;
        fin = 1'b1;
      end else if (phase == rle_pkg::PhHeader) begin
        if (it.data_byte[7]) begin
          run_left = {1'b0, it.data_byte[6:0]} + rle_pkg::RepeatBias;
          phase = rle_pkg::PhRepeat;
        end else begin
          run_left = it.data_byte + 8'd1;
          phase = rle_pkg::PhLiteral;
        end
        col_byte = '0;
      end else begin
        if (cfg_pal_mode) begin
          pix = pal_mem[it.data_byte];
          col_byte = '0;
          done = 1'b1;
        end else begin
          if (col_byte == 2'd0) col_acc = {24'h0, it.data_byte};
          else col_acc = col_acc | ({24'h0, it.data_byte} << (8 * col_byte));
          col_byte = col_byte + 2'd1;
          if (col_byte == 2'd0) begin
            pix = col_acc;
            done = 1'b1;
          end
        end
        if (done) begin
          if (phase == rle_pkg::PhRepeat) begin
            run = (rle_pkg::CountW'(run_left) > room) ? room[7:0] : run_left;
            run_left = '0;
            phase = rle_pkg::PhHeader;
          end else begin
            run = 8'd1;
            if (run_left != '0) run_left = run_left - 8'd1;
            if (run_left == '0) phase = rle_pkg::PhHeader;
          end
          px_count = px_count + rle_pkg::CountW'(run);
          got = 1'b1;
          if (px_count >= cfg_limit) begin
            fin = 1'b1;
            halted = 1'b1;
          end
        end
      end
    end
    if (it.end_of_chunk) begin
      if (!was_halted) begin
        if (!got) begin
          got = 1'b1;
          pix = '0;
          run = '0;
        end
        fin = 1'b1;
      end
      rearm_decoder();
    end
    res.pixel = pix;
    res.run_length = run;
    res.final_res = fin;
  endfunction

  function automatic rle_pkg::in_item_t mk_item(input logic mode, input logic [7:0] sel,
                                                input logic [31:0] word, input logic eoc);
    rle_pkg::in_item_t it;
    it.mode = mode;
    it.data_byte = mode ? 8'($urandom) : sel;
    it.palette_index = mode ? sel : 8'($urandom);
    it.palette_word = word;
    it.end_of_chunk = eoc;
    return it;
  endfunction

  function automatic logic [rle_pkg::CfgDataW-1:0] pick_limit();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    else if (pick < 4) return rle_pkg::CfgDataW'(rle_pkg::OutLimitReset);
    else if (pick == 4) return rle_pkg::CfgDataW'($urandom);
    else if (pick < 7) return rle_pkg::CfgDataW'($urandom_range(1, 8));
    else return rle_pkg::CfgDataW'($urandom_range(9, 400));
  endfunction

  task automatic send_item(input rle_pkg::in_item_t it, input bit typed,
                           input rle_pkg::out_item_t want);
    bit                 got;
    rle_pkg::out_item_t res;
    repeat (next_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    transfers++;
    decode_item(it, got, res);
    if (typed) pending_pixels = {pending_pixels, want};
    else if (got) pending_pixels = {pending_pixels, res};
    next_gap = src_calm ? 0 : $urandom_range(0, 10);
    src_hold = (next_gap == 0);
    if (!src_hold) in_valid_i <= 1'b0;
  endtask

  task automatic send_load(input logic [7:0] idx, input logic [31:0] word);
    send_item(mk_item(1'b1, idx, word, 1'($urandom)), 1'b0, '0);
  endtask

  // a colour byte in palette mode never reads an entry that was not loaded
  task automatic send_data(input logic [7:0] b, input logic eoc);
    if (cfg_pal_mode && !halted && room_left() != '0 && phase != rle_pkg::PhHeader &&
        !pal_written[b])
      send_load(b, 32'($urandom));
    send_item(mk_item(1'b0, b, 32'($urandom), eoc), 1'b0, '0);
  endtask

  task automatic drain_results();
    if (src_hold) begin
      in_valid_i <= 1'b0;
      src_hold = 1'b0;
    end
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rle_pkg::CfgIdxW-1:0] idx,
                           input logic [rle_pkg::CfgDataW-1:0] val);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rle_pkg::CfgPaletteMode) cfg_pal_mode = val[0];
    else cfg_limit = val[rle_pkg::CountW-1:0];
    cfg_writes++;
  endtask

  task automatic shuffle_cfg();
    if ($urandom_range(0, 1))
      write_reg(rle_pkg::CfgPaletteMode, rle_pkg::CfgDataW'($urandom_range(0, 1)));
    else write_reg(rle_pkg::CfgOutLimit, pick_limit());
  endtask

  task automatic mix_noise();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) send_load(8'($urandom), 32'($urandom));
    else if (pick < 6) send_data(8'($urandom), 1'b0);
    else if (pick < 8) shuffle_cfg();
  endtask

  task automatic gen_chunk();
    int unsigned runs, npix;
    int          r, p, b;
    bit          end_on_pixel, rep, cut, last;
    logic [7:0]  hdr;
    end_on_pixel = $urandom_range(0, 1);
    runs = $urandom_range(1, 5);
    for (r = 0; r < runs; r++) begin
      rep = $urandom_range(0, 1);
      if (rep) hdr = {1'b1, 7'($urandom)};
      else if ($urandom_range(0, 7) == 0) hdr = {1'b0, 7'($urandom)};
      else hdr = 8'($urandom_range(0, 3));
      send_data(hdr, 1'b0);
      npix = rep ? 1 : hdr + 1;
      cut = 1'b0;
      if (npix > 6) begin
        npix = $urandom_range(1, 6);
        cut = 1'b1;
      end
      for (p = 0; p < npix; p++) begin
        for (b = 0; b < 4; b++) begin
          if (b != 0 && cfg_pal_mode) break;
          mix_noise();
          last = end_on_pixel && !cut && r == runs - 1 && p == npix - 1 &&
                 (cfg_pal_mode || b == 3);
          send_data(8'($urandom), last);
          if (last) return;
        end
      end
      if (cut && $urandom_range(0, 1)) break;
    end
    send_data(8'($urandom), 1'b1);
  endtask

  task automatic gen_noise_chunk();
    int unsigned n;
    int          k;
    n = $urandom_range(1, 20);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) send_load(8'($urandom), 32'($urandom));
      else send_data(8'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  // result transfer check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h/%0d/%0d", $time,
                 out_item_o.pixel, out_item_o.run_length, out_item_o.final_res);
        fails++;
      end else begin
        want_pix = pending_pixels.pop_front();
        if (out_item_o.pixel !== want_pix.pixel) begin
          $display("%0t: pixel expected %h actual %h", $time, want_pix.pixel,
                   out_item_o.pixel);
          fails++;
        end
        if (out_item_o.run_length !== want_pix.run_length) begin
          $display("%0t: run_length expected %0d actual %0d", $time,
                   want_pix.run_length, out_item_o.run_length);
          fails++;
        end
        if (out_item_o.final_res !== want_pix.final_res) begin
          $display("%0t: final_res expected %0d actual %0d", $time,
                   want_pix.final_res, out_item_o.final_res);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogCycles) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("FAIL rle_pixel_run_decoder_core");
      $finish;
    end
  end

  // result receiver with random stalls
  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      if (taken % 50 == 0) sink_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int       i;
    dir_row_t row;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    for (i = 0; i < rle_pkg::PalEntries; i++) begin
      pal_mem[i] = '0;
      pal_written[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirRows; i++) begin
      row = DirTable[i];
      if (row.kind == RowCfg) begin
        write_reg(row.sel[rle_pkg::CfgIdxW-1:0], row.word[rle_pkg::CfgDataW-1:0]);
      end else begin
        send_item(mk_item(row.kind == RowLoad, row.sel,
                          (row.kind == RowLoad) ? row.word : 32'($urandom), row.eoc),
                  row.typed, row.want);
      end
    end

    while (transfers < RandItems) begin
      src_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) shuffle_cfg();
      if ($urandom_range(0, 9) == 0) gen_noise_chunk();
      else gen_chunk();
      chunks++;
    end

    drain_results();
    repeat (6) @(posedge clk_i);
    $display("covered %0d input transfers (%0d not ignored), %0d results, %0d chunks",
             transfers, live_items, results_seen, chunks);
    $display("%0d register writes over direct and palette colours, limits zero to full",
             cfg_writes);
    if (fails == 0) $display("PASS rle_pixel_run_decoder_core");
    else $display("FAIL rle_pixel_run_decoder_core");
    $finish;
  end

endmodule
